### rtl/sutset_pkg.sv
// ============================================================================
// sutset_pkg
// Shared types, constants and helpers for the sorted unique tuple set.
// ============================================================================
`default_nettype none

package sutset_pkg;

    localparam int CAPACITY    = 64;
    localparam int MAX_ARITY   = 8;
    localparam int SYMBOL_BITS = 8;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int WORD_W      = 64;

    typedef enum logic [2:0] {
        REQ_ADD         = 3'd0,
        REQ_REMOVE      = 3'd1,
        REQ_SET         = 3'd2,
        REQ_CLEAR       = 3'd3,
        REQ_REMOVE_CONT = 3'd4,
        REQ_CONTAINS    = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_CHANGED   = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUP       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_EVAL,
        CELL_SORT,
        CELL_INSERT,
        CELL_SET
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        t_cell_op            op;
        logic [2:0]          req;
        logic [WORD_W-1:0]   key;
        logic [WORD_W-1:0]   amask;
        logic [7:0]          cmask;
        logic [7:0]          val;
        logic [CNT_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
        logic                phase;
    } t_cell_ctrl;

    // Clamp the arity register into 1..MAX_ARITY.
    function automatic logic [3:0] eff_arity(input logic [3:0] a);
        logic [3:0] r;
        r = a;
        if (r == 4'd0) r = 4'd1;
        if (r > 4'(MAX_ARITY)) r = 4'(MAX_ARITY);
        return r;
    endfunction

    // Mask that keeps the used symbols of a tuple word, symbol 0 on top.
    function automatic logic [WORD_W-1:0] arity_mask(input logic [3:0] a);
        logic [WORD_W-1:0] m;
        logic [3:0]        ea;
        m  = '0;
        ea = eff_arity(a);
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < ea) begin
                m[WORD_W-1-8*j -: 8] = 8'((1 << SYMBOL_BITS) - 1);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/sutset_cell.sv
// ============================================================================
// sutset_cell
// One slot of the tuple chain: holds an entry, compares it with the request
// key, and trades entries with its neighbors on inserts and compaction.
// ============================================================================
`default_nettype none

module sutset_cell (
    input  wire logic                              i_clk,
    input  wire logic [sutset_pkg::IDX_W-1:0]      i_index,
    input  wire sutset_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic [sutset_pkg::WORD_W-1:0]     i_left_data,
    input  wire logic                              i_left_keep,
    input  wire logic [sutset_pkg::WORD_W-1:0]     i_right_data,
    input  wire logic                              i_right_keep,
    output logic [sutset_pkg::WORD_W-1:0]          o_data,
    output logic                                   o_keep,
    output logic                                   o_lt,
    output logic                                   o_hit
);

    logic [sutset_pkg::WORD_W-1:0] r_data, n_data;
    logic r_keep, n_keep, r_lt, n_lt, r_hit, n_hit;

    logic [sutset_pkg::WORD_W-1:0] w_ke;
    logic w_eq, w_col, w_hit, w_pair_right, w_pair_left;
    logic [sutset_pkg::CNT_W-1:0] w_idx;

    assign w_idx = sutset_pkg::CNT_W'(i_index);
    assign w_ke  = r_data & i_ctrl.amask;
    assign w_eq  = (w_ke == i_ctrl.key);

    always_comb begin
        w_col = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (i_ctrl.cmask[j] && (|i_ctrl.amask[sutset_pkg::WORD_W-1-8*j -: 8]) &&
                (w_ke[sutset_pkg::WORD_W-1-8*j -: 8] == i_ctrl.val)) begin
                w_col = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_ctrl.req)
            sutset_pkg::REQ_REMOVE_CONT: w_hit = w_col;
            sutset_pkg::REQ_CONTAINS:    w_hit = (w_ke[sutset_pkg::WORD_W-1 -: 8] == i_ctrl.val);
            default:                     w_hit = w_eq;
        endcase
    end

    // Odd-even transposition: a kept entry moves left past a dropped one.
    assign w_pair_right = (i_index[0] == i_ctrl.phase);
    assign w_pair_left  = !w_pair_right;

    always_comb begin
        n_data = r_data;
        n_keep = r_keep;
        n_lt   = r_lt;
        n_hit  = r_hit;
        case (i_ctrl.op)
            sutset_pkg::CELL_EVAL: begin
                n_lt   = (w_ke < i_ctrl.key);
                n_hit  = w_hit;
                n_keep = (w_idx < i_ctrl.count) &&
                         !(w_hit && ((i_ctrl.req == sutset_pkg::REQ_REMOVE) ||
                                     (i_ctrl.req == sutset_pkg::REQ_REMOVE_CONT)));
            end
            sutset_pkg::CELL_SORT: begin
                if (w_pair_right && !r_keep && i_right_keep) begin
                    n_data = i_right_data;
                    n_keep = 1'b1;
                end else if (w_pair_left && !i_left_keep && r_keep) begin
                    n_data = i_left_data;
                    n_keep = 1'b0;
                end
            end
            sutset_pkg::CELL_INSERT: begin
                if (w_idx == i_ctrl.pos) begin
                    n_data = i_ctrl.key;
                end else if (w_idx > i_ctrl.pos) begin
                    n_data = i_left_data;
                end
            end
            sutset_pkg::CELL_SET: begin
                if (w_idx == '0) begin
                    n_data = i_ctrl.key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_keep <= n_keep;
        r_lt   <= n_lt;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_keep = r_keep;
    assign o_lt   = r_lt;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

### rtl/sorted_unique_tuple_set_top.sv
// ============================================================================
// sorted_unique_tuple_set_top
// Sorted, duplicate-free store of tuples held in a chain of entry cells.
// ============================================================================
// Usage: a request item enters on i_in_valid/o_in_ready and one result item
// leaves on o_out_valid/i_out_ready. The block works on one item at a time;
// o_in_ready is high only while no item is in flight.
// Sequence: set, clear, unknown codes and adds rejected as full go from the
// execute state straight to the result. Add, remove, remove containing and
// contains run one compare step in every cell, then a scan of all CAPACITY
// cells that reads one cell's flags per cycle to find duplicates, the insert
// position and the removals, while removals compact the chain by odd-even
// exchanges between neighbor cells. A final step inserts or updates the
// count, or sets the found flag for contains.
// Stall: the result is held in output registers until taken; the next item
// is accepted in the cycle after the result leaves.
// Reset: the count clears, arity returns to 1 and the limit to 64. Entry
// contents are not cleared. Config registers: arity at 0x0, limit at 0x4. The
// user writes them over APB only while the block is idle; it is unenforced.
// ============================================================================
`default_nettype none

module sorted_unique_tuple_set_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [63:0] i_tuple_word,
    input  wire logic [7:0]  i_column_mask,
    input  wire logic [7:0]  i_match_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [6:0]       o_entry_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int N = sutset_pkg::CAPACITY;

    sutset_pkg::t_state r_state, n_state;
    logic [3:0]  r_arity;
    logic [6:0]  r_cap;
    logic [2:0]  r_req, n_req;
    logic [63:0] r_key, n_key;
    logic [7:0]  r_cmask, n_cmask, r_val, n_val;
    logic [sutset_pkg::CNT_W-1:0] r_count, n_count, r_pos, n_pos, r_removed, n_removed;
    logic [sutset_pkg::IDX_W-1:0] r_k, n_k;
    logic r_found, n_found, r_seen, n_seen;
    logic [1:0] r_status, n_status;
    logic r_ofound, n_ofound;

    logic [63:0] w_amask;
    logic [sutset_pkg::CNT_W-1:0] w_cap;
    logic w_cfg_wr;
    sutset_pkg::t_cell_ctrl w_ctrl;

    logic [63:0] w_data [N];
    logic [N-1:0] w_keep, w_lt, w_hit;

    assign w_amask = sutset_pkg::arity_mask(r_arity);
    assign w_cap   = (r_cap > 7'(N)) ? sutset_pkg::CNT_W'(N) : sutset_pkg::CNT_W'(r_cap);

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = paddr[2] ? {25'd0, r_cap} : {28'd0, r_arity};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arity <= 4'd1;
            r_cap   <= 7'd64;
        end else if (w_cfg_wr) begin
            if (paddr[2]) begin
                r_cap <= pwdata[6:0];
            end else begin
                r_arity <= pwdata[3:0];
            end
        end
    end

    // Cell chain.
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [63:0] w_ld, w_rd;
            logic        w_lk, w_rk;
            if (g == 0) begin : g_first
                assign w_ld = '0;
                assign w_lk = 1'b1;
            end else begin : g_mid_l
                assign w_ld = w_data[g-1];
                assign w_lk = w_keep[g-1];
            end
            if (g == N - 1) begin : g_last
                assign w_rd = '0;
                assign w_rk = 1'b0;
            end else begin : g_mid_r
                assign w_rd = w_data[g+1];
                assign w_rk = w_keep[g+1];
            end
            sutset_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (sutset_pkg::IDX_W'(g)),
                .i_ctrl       (w_ctrl),
                .i_left_data  (w_ld),
                .i_left_keep  (w_lk),
                .i_right_data (w_rd),
                .i_right_keep (w_rk),
                .o_data       (w_data[g]),
                .o_keep       (w_keep[g]),
                .o_lt         (w_lt[g]),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sutset_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req     <= n_req;
        r_key     <= n_key;
        r_cmask   <= n_cmask;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_removed <= n_removed;
        r_k       <= n_k;
        r_found   <= n_found;
        r_seen    <= n_seen;
        r_status  <= n_status;
        r_ofound  <= n_ofound;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_req     = r_req;
        n_key     = r_key;
        n_cmask   = r_cmask;
        n_val     = r_val;
        n_pos     = r_pos;
        n_removed = r_removed;
        n_k       = r_k;
        n_found   = r_found;
        n_seen    = r_seen;
        n_status  = r_status;
        n_ofound  = r_ofound;

        w_ctrl.op    = sutset_pkg::CELL_HOLD;
        w_ctrl.req   = r_req;
        w_ctrl.key   = r_key;
        w_ctrl.amask = w_amask;
        w_ctrl.cmask = r_cmask;
        w_ctrl.val   = r_val;
        w_ctrl.pos   = r_pos;
        w_ctrl.count = r_count;
        w_ctrl.phase = r_k[0];

        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        unique case (r_state)
            sutset_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_key   = i_tuple_word & w_amask;
                    n_cmask = i_column_mask;
                    n_val   = i_match_value;
                    n_state = sutset_pkg::S_EXEC;
                end
            end
            sutset_pkg::S_EXEC: begin
                n_status  = sutset_pkg::ST_NO_CHANGE;
                n_ofound  = 1'b0;
                n_k       = '0;
                n_found   = 1'b0;
                n_seen    = 1'b0;
                n_pos     = r_count;
                n_removed = '0;
                n_state   = sutset_pkg::S_OUT;
                case (r_req)
                    sutset_pkg::REQ_SET: begin
                        if (w_cap == '0) begin
                            n_status = sutset_pkg::ST_FULL;
                        end else begin
                            w_ctrl.op = sutset_pkg::CELL_SET;
                            n_count   = sutset_pkg::CNT_W'(1);
                            n_status  = sutset_pkg::ST_CHANGED;
                        end
                    end
                    sutset_pkg::REQ_CLEAR: begin
                        n_count  = '0;
                        n_status = sutset_pkg::ST_CHANGED;
                    end
                    sutset_pkg::REQ_ADD: begin
                        if (r_count >= w_cap) begin
                            n_status = sutset_pkg::ST_FULL;
                        end else begin
                            w_ctrl.op = sutset_pkg::CELL_EVAL;
                            n_state   = sutset_pkg::S_SCAN;
                        end
                    end
                    sutset_pkg::REQ_REMOVE, sutset_pkg::REQ_REMOVE_CONT,
                    sutset_pkg::REQ_CONTAINS: begin
                        w_ctrl.op = sutset_pkg::CELL_EVAL;
                        n_state   = sutset_pkg::S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            sutset_pkg::S_SCAN: begin
                if ((r_req == sutset_pkg::REQ_REMOVE) ||
                    (r_req == sutset_pkg::REQ_REMOVE_CONT)) begin
                    w_ctrl.op = sutset_pkg::CELL_SORT;
                end
                if (sutset_pkg::CNT_W'(r_k) < r_count) begin
                    if (w_hit[r_k]) begin
                        n_found   = 1'b1;
                        n_removed = r_removed + sutset_pkg::CNT_W'(1);
                    end
                    if (!r_seen && !w_lt[r_k]) begin
                        n_seen = 1'b1;
                        n_pos  = sutset_pkg::CNT_W'(r_k);
                    end
                end
                n_k = r_k + sutset_pkg::IDX_W'(1);
                if (r_k == sutset_pkg::IDX_W'(N - 1)) begin
                    n_state = sutset_pkg::S_DONE;
                end
            end
            sutset_pkg::S_DONE: begin
                n_state = sutset_pkg::S_OUT;
                case (r_req)
                    sutset_pkg::REQ_ADD: begin
                        if (r_found) begin
                            n_status = sutset_pkg::ST_DUP;
                        end else begin
                            w_ctrl.op = sutset_pkg::CELL_INSERT;
                            n_count   = r_count + sutset_pkg::CNT_W'(1);
                            n_status  = sutset_pkg::ST_CHANGED;
                        end
                    end
                    sutset_pkg::REQ_CONTAINS: begin
                        n_ofound = r_found && (sutset_pkg::eff_arity(r_arity) == 4'd1);
                    end
                    default: begin
                        n_count  = r_count - r_removed;
                        n_status = r_found ? sutset_pkg::ST_CHANGED : sutset_pkg::ST_NO_CHANGE;
                    end
                endcase
            end
            sutset_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = sutset_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sutset_pkg::S_IDLE;
            end
        endcase
    end

    assign o_status      = r_status;
    assign o_found       = r_ofound;
    assign o_entry_count = 7'(r_count);

endmodule

`default_nettype wire

### rtl/sutset_checker.sv
// ============================================================================
// sutset_checker
// Port-level checks for the sorted unique tuple set, bound to the top level.
// ============================================================================
`default_nettype none

module sutset_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_status,
    input wire logic       o_found,
    input wire logic [6:0] o_entry_count,
    input wire logic       pready
);

    // Only one item is in flight, so input and output never overlap.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_found_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == 2'd1))
        else $error("found reported with a changing status");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= 7'd64))
        else $error("entry count above capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status) &&
                                           $stable(o_entry_count)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind sorted_unique_tuple_set_top sutset_checker u_sutset_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_found       (o_found),
    .o_entry_count (o_entry_count),
    .pready        (pready)
);

`default_nettype wire

### tb/tb_sorted_unique_tuple_set_top.sv
// ============================================================================
// tb_sorted_unique_tuple_set_top
// Self-checking bench for the sorted unique tuple set.
// ============================================================================
// A directed table and then random request items drive the block through
// the valid/ready channels. A behavioral copy of the tuple store predicts
// every result item, and the results are compared in order. The arity and
// limit registers are changed over APB between phases while the block is
// idle.
// ============================================================================
`default_nettype none

module tb_sorted_unique_tuple_set_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 1500000;
    localparam int  N_RANDOM     = 800;
    localparam int  DRAIN_CYCLES = 80;
    localparam logic [2:0] ADDR_ARITY = 3'd0;
    localparam logic [2:0] ADDR_LIMIT = 3'd4;
    localparam logic [2:0] REQ_BAD6   = 3'd6;
    localparam logic [2:0] REQ_BAD7   = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [6:0] count;
    } t_result;

    typedef struct {
        logic [2:0]  req;
        logic [63:0] word;
        logic [7:0]  cmask;
        logic [7:0]  val;
        bit          has_exp;
        t_result     exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type = '0;
    logic [63:0] i_tuple_word = '0;
    logic [7:0]  i_column_mask = '0;
    logic [7:0]  i_match_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_found;
    logic [6:0]  o_entry_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sorted_unique_tuple_set_top u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state.
    logic [63:0] set_entries [sutset_pkg::CAPACITY];
    int          set_count;
    logic [3:0]  arity_reg;
    logic [6:0]  limit_reg;

    t_result     pending_results [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm_out = 1'b0;

    function automatic int arity_used();
        if (arity_reg == 0) return 1;
        if (arity_reg > sutset_pkg::MAX_ARITY) return sutset_pkg::MAX_ARITY;
        return arity_reg;
    endfunction

    function automatic logic [63:0] tuple_key(logic [63:0] w);
        logic [63:0] k;
        k = '0;
        for (int j = 0; j < arity_used(); j++) k[63-8*j -: 8] = w[63-8*j -: 8];
        return k;
    endfunction

    function automatic bit hit_column(logic [63:0] k, logic [7:0] cm, logic [7:0] v);
        for (int j = 0; j < arity_used(); j++)
            if (cm[j] && k[63-8*j -: 8] == v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_result apply_request(logic [2:0] req, logic [63:0] word,
                                              logic [7:0] cm, logic [7:0] v);
        t_result     r;
        logic [63:0] key;
        logic [63:0] ek;
        int          lim, pos, dst;
        bit          any;
        key = tuple_key(word);
        lim = (limit_reg > sutset_pkg::CAPACITY) ? sutset_pkg::CAPACITY : limit_reg;
        r.status = sutset_pkg::ST_NO_CHANGE;
        r.found = 1'b0;
        case (req)
            sutset_pkg::REQ_ADD: begin
                if (set_count >= lim) begin
                    r.status = sutset_pkg::ST_FULL;
                end else begin
                    r.status = sutset_pkg::ST_CHANGED;
                    for (int i = 0; i < set_count; i++)
                        if (tuple_key(set_entries[i]) == key) r.status = sutset_pkg::ST_DUP;
                    if (r.status == sutset_pkg::ST_CHANGED) begin
                        pos = 0;
                        while (pos < set_count && tuple_key(set_entries[pos]) < key) pos++;
                        for (int i = set_count; i > pos; i--) set_entries[i] = set_entries[i-1];
                        set_entries[pos] = key;
                        set_count++;
                    end
                end
            end
            sutset_pkg::REQ_REMOVE, sutset_pkg::REQ_REMOVE_CONT: begin
                dst = 0;
                any = 1'b0;
                for (int i = 0; i < set_count; i++) begin
                    if (req == sutset_pkg::REQ_REMOVE ?
                        tuple_key(set_entries[i]) == key :
                        hit_column(tuple_key(set_entries[i]), cm, v)) begin
                        any = 1'b1;
                    end else begin
                        set_entries[dst] = set_entries[i];
                        dst++;
                    end
                end
                set_count = dst;
                r.status = any ? sutset_pkg::ST_CHANGED : sutset_pkg::ST_NO_CHANGE;
            end
            sutset_pkg::REQ_SET: begin
                if (lim < 1) begin
                    r.status = sutset_pkg::ST_FULL;
                end else begin
                    set_entries[0] = key;
                    set_count = 1;
                    r.status = sutset_pkg::ST_CHANGED;
                end
            end
            sutset_pkg::REQ_CLEAR: begin
                set_count = 0;
                r.status = sutset_pkg::ST_CHANGED;
            end
            sutset_pkg::REQ_CONTAINS: begin
                if (arity_used() == 1)
                    for (int i = 0; i < set_count; i++) begin
                        ek = tuple_key(set_entries[i]);
                        if (ek[63:56] == v) r.found = 1'b1;
                    end
            end
            default: r.status = sutset_pkg::ST_NO_CHANGE;
        endcase
        r.count = 7'(set_count);
        return r;
    endfunction

    // Result checker and receiver idling.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n) begin
            i_out_ready <= calm_out || ($urandom_range(99) >= 32);
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("unexpected result item at cycle %0d", cycles);
                end else begin
                    t_result want;
                    want = pending_results.pop_front();
                    if (want != {o_status, o_found, o_entry_count}) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: want st=%0d f=%0d n=%0d got st=%0d f=%0d n=%0d",
                                     want.status, want.found, want.count,
                                     o_status, o_found, o_entry_count);
                    end
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_ARITY) arity_reg = data[3:0];
        else limit_reg = data[6:0];
        @(posedge i_clk);
    endtask

    // Waits for all results, then lets the block sit idle for a while.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_request(logic [2:0] req, logic [63:0] word, logic [7:0] cm,
                                logic [7:0] v, bit calm, bit has_exp, t_result exp);
        t_result got;
        if (!calm && ($urandom_range(99) < 32)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 32) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_tuple_word <= word;
        i_column_mask <= cm;
        i_match_value <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = apply_request(req, word, cm, v);
        if (has_exp && got != exp) begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees: req=%0d want %p predicted %p", req, exp, got);
        end
        pending_results.push_back(has_exp ? exp : got);
    endtask

    function automatic logic [63:0] tuple_from_pool();
        logic [63:0] w;
        w = {$urandom, $urandom};
        for (int j = 0; j < 8; j++)
            if ($urandom_range(3) != 0) w[63-8*j -: 8] = 8'($urandom_range(3));
        return w;
    endfunction

    t_row table_rows [] = '{
        '{sutset_pkg::REQ_CONTAINS, 64'h0, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b0, 7'd0}},
        '{sutset_pkg::REQ_REMOVE, 64'h0, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b0, 7'd0}},
        '{sutset_pkg::REQ_ADD, 64'hFF00_0000_0000_0000, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_CHANGED, 1'b0, 7'd1}},
        '{sutset_pkg::REQ_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_DUP, 1'b0, 7'd1}},
        '{sutset_pkg::REQ_ADD, 64'h0000_0000_0000_0000, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_CHANGED, 1'b0, 7'd2}},
        '{sutset_pkg::REQ_ADD, 64'h7F12_3456_789A_BCDE, 8'h00, 8'h00, 0,
          '{2'd0, 1'b0, 7'd0}},
        '{sutset_pkg::REQ_CONTAINS, 64'h0, 8'h00, 8'hFF, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b1, 7'd3}},
        '{sutset_pkg::REQ_CONTAINS, 64'h0, 8'h00, 8'h80, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b0, 7'd3}},
        '{sutset_pkg::REQ_REMOVE_CONT, 64'h0, 8'hFE, 8'h7F, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b0, 7'd3}},
        '{sutset_pkg::REQ_REMOVE_CONT, 64'h0, 8'h01, 8'h7F, 1,
          '{sutset_pkg::ST_CHANGED, 1'b0, 7'd2}},
        '{REQ_BAD6, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b0, 7'd2}},
        '{REQ_BAD7, 64'h0, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_NO_CHANGE, 1'b0, 7'd2}},
        '{sutset_pkg::REQ_REMOVE, 64'h00AA_0000_0000_0000, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_CHANGED, 1'b0, 7'd1}},
        '{sutset_pkg::REQ_SET, 64'h4200_0000_0000_0000, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_CHANGED, 1'b0, 7'd1}},
        '{sutset_pkg::REQ_CLEAR, 64'h0, 8'h00, 8'h00, 1,
          '{sutset_pkg::ST_CHANGED, 1'b0, 7'd0}}
    };

    initial begin
        int          n_phase;
        logic [2:0]  req;
        logic [63:0] word;
        arity_reg = 4'd1;
        limit_reg = 7'd64;
        set_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[r])
            send_request(table_rows[r].req, table_rows[r].word, table_rows[r].cmask,
                         table_rows[r].val, 1'b0, table_rows[r].has_exp, table_rows[r].exp);
        settle();

        // Full store at the largest limit, with wide tuples, then a zero limit.
        reg_write(ADDR_ARITY, 32'd8);
        for (int i = 0; i < 66; i++)
            send_request(sutset_pkg::REQ_ADD, {$urandom, $urandom}, '0, '0, 1'b0, 1'b0, '0);
        settle();
        reg_write(ADDR_LIMIT, 32'd0);
        send_request(sutset_pkg::REQ_SET, '1, '0, '0, 1'b0, 1'b1,
                     '{sutset_pkg::ST_FULL, 1'b0, 7'd64});
        send_request(sutset_pkg::REQ_ADD, '0, '0, '0, 1'b0, 1'b1,
                     '{sutset_pkg::ST_FULL, 1'b0, 7'd64});
        send_request(sutset_pkg::REQ_CLEAR, '0, '0, '0, 1'b0, 1'b1,
                     '{sutset_pkg::ST_CHANGED, 1'b0, 7'd0});
        settle();
        reg_write(ADDR_ARITY, 32'd15);
        reg_write(ADDR_LIMIT, 32'd127);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            // The arity also changes while tuples are still stored.
            reg_write(ADDR_ARITY, phase == 0 ? 32'd0 : 32'($urandom_range(15)));
            reg_write(ADDR_LIMIT, phase == 1 ? 32'd1 : 32'($urandom_range(127)));
            calm_out = (phase == 3);
            n_phase = N_RANDOM / 8;
            for (int k = 0; k < n_phase; k++) begin
                word = tuple_from_pool();
                case ($urandom_range(99)) inside
                    [0:44]:  req = sutset_pkg::REQ_ADD;
                    [45:59]: req = sutset_pkg::REQ_REMOVE;
                    [60:69]: req = sutset_pkg::REQ_CONTAINS;
                    [70:81]: req = sutset_pkg::REQ_REMOVE_CONT;
                    [82:89]: req = sutset_pkg::REQ_SET;
                    [90:94]: req = sutset_pkg::REQ_CLEAR;
                    default: req = 3'($urandom_range(7));
                endcase
                if (req == sutset_pkg::REQ_REMOVE && set_count > 0 && $urandom_range(1))
                    word = set_entries[$urandom_range(set_count - 1)] | (64'($urandom) & 64'hFF);
                send_request(req, word, 8'($urandom), ($urandom_range(3) == 0) ?
                             8'($urandom) : 8'($urandom_range(3)), phase == 3, 1'b0, '0);
            end
            settle();
        end
        calm_out = 1'b0;

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/sutset_pkg.sv
rtl/sutset_cell.sv
rtl/sorted_unique_tuple_set_top.sv
rtl/sutset_checker.sv
tb/tb_sorted_unique_tuple_set_top.sv
